[rtl/tsg_pkg.sv]
// ----------------------------------------------------------------------------
// tsg_pkg
// Types, widths and helpers for the tetrahedron shape-gradient pipeline.
// ----------------------------------------------------------------------------
package tsg_pkg;

    localparam int CW        = 32;   // coordinate width, Q16.16
    localparam int JW        = CW + 1;
    localparam int PW        = 2 * JW;
    localparam int AW        = PW + 1;
    localparam int LOW_W     = 34;   // low split of an adjugate entry
    localparam int HIGH_W    = AW - LOW_W;
    localparam int PLO_W     = JW + LOW_W + 1;
    localparam int PHI_W     = JW + HIGH_W;
    localparam int DW        = 100;  // exact determinant, Q52.48
    localparam int NW        = AW + 1;
    localparam int QW        = 32;
    localparam int DQW       = DW - 32;
    localparam int DETW      = 64;
    localparam int DIV_STEPS = QW;
    localparam int NODES     = 4;
    localparam int AXES      = 3;
    localparam int FRONT_STAGES = 7;

    localparam logic [13:0] WEIGHT_SIXTH = 14'd10923;
    localparam logic [1:0]  LAST_NODE    = 2'd3;

    typedef struct packed {
        logic signed [CW-1:0] node0_x;
        logic signed [CW-1:0] node0_y;
        logic signed [CW-1:0] node0_z;
        logic signed [CW-1:0] node1_x;
        logic signed [CW-1:0] node1_y;
        logic signed [CW-1:0] node1_z;
        logic signed [CW-1:0] node2_x;
        logic signed [CW-1:0] node2_y;
        logic signed [CW-1:0] node2_z;
        logic signed [CW-1:0] node3_x;
        logic signed [CW-1:0] node3_y;
        logic signed [CW-1:0] node3_z;
    } tsg_in_t;

    typedef struct packed {
        logic [1:0]             node_index;
        logic signed [QW-1:0]   dn_dx;
        logic signed [QW-1:0]   dn_dy;
        logic signed [QW-1:0]   dn_dz;
        logic signed [DETW-1:0] det_j;
        logic [13:0]            ip_weight;
        logic                   singular;
        logic                   last;
    } tsg_out_t;

    typedef struct packed {
        logic [AXES-1:0][DW-1:0] rem;
        logic [AXES-1:0][QW-1:0] quo;
        logic [AXES-1:0]         neg;
        logic [AXES-1:0]         big;
        logic [DW-1:0]           dabs;
        logic [DETW-1:0]         detq;
        logic                    sing;
        logic [1:0]              idx;
    } tsg_div_t;

    function automatic tsg_div_t div_step(input tsg_div_t a);
        tsg_div_t  r;
        logic [DW:0] r2;
        r = a;
        for (int l = 0; l < AXES; l++)
        begin
            r2 = {a.rem[l], 1'b0};
            if (r2 >= {1'b0, a.dabs})
            begin
                r.rem[l] = DW'(r2 - {1'b0, a.dabs});
                r.quo[l] = {a.quo[l][QW-2:0], 1'b1};
            end
            else
            begin
                r.rem[l] = r2[DW-1:0];
                r.quo[l] = {a.quo[l][QW-2:0], 1'b0};
            end
        end
        return r;
    endfunction

    function automatic logic [QW-1:0] finish_quo(input logic sing, input logic big,
                                                 input logic neg, input logic [QW-1:0] mag);
        logic [QW-1:0] r;
        r = '0;
        if (sing)
            r = '0;
        else if (big)
            r = neg ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
        else if (neg)
            r = (mag > {1'b1, {(QW-1){1'b0}}}) ? {1'b1, {(QW-1){1'b0}}} : QW'(-mag);
        else
            r = mag[QW-1] ? {1'b0, {(QW-1){1'b1}}} : mag;
        return r;
    endfunction

endpackage

[rtl/tet4_shape_gradient.sv]
// ----------------------------------------------------------------------------
// tet4_shape_gradient
// Spatial shape-function gradients of a four-node linear tetrahedron.
// ----------------------------------------------------------------------------
// One element beat in gives four result beats out, node 0 to node 3, the
// last flagged. The block takes a new element only while the single
// serializer is empty or releases its last node; the serializer feeds one
// node a cycle, while the result side does not stall, into the shared
// three-lane restoring divider (one quotient bit per stage, 32 stages). A
// zero determinant sets singular and forces all derivatives to zero.
module tet4_shape_gradient
    import tsg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_ready,
    input  tsg_in_t  item,
    output logic     result_valid,
    input  logic     result_ready,
    output tsg_out_t result
);

    logic adv;
    logic front_adv;

    logic [FRONT_STAGES:1] fv_reg;
    logic [FRONT_STAGES:1] fv_next;

    logic signed [CW-1:0] crd [NODES][AXES];

    logic signed [JW-1:0] j1_reg [AXES][AXES];
    logic signed [JW-1:0] j0_2_reg [AXES];
    logic signed [PW-1:0] pa_reg [AXES][AXES];
    logic signed [PW-1:0] pb_reg [AXES][AXES];
    logic signed [JW-1:0] j0_3_reg [AXES];
    logic signed [AW-1:0] adj3_reg [AXES][AXES];
    logic signed [PLO_W-1:0] plo_reg [AXES];
    logic signed [PHI_W-1:0] phi_reg [AXES];
    logic signed [AW-1:0] adj4_reg [AXES][AXES];
    logic signed [DW-1:0] term_reg [AXES];
    logic signed [NW-1:0] num5_reg [NODES][AXES];
    logic signed [DW-1:0] det_reg;
    logic signed [NW-1:0] num6_reg [NODES][AXES];
    logic signed [NW-1:0] num7_reg [NODES][AXES];
    logic [DW-1:0]        dabs7_reg;
    logic [DETW-1:0]      detq7_reg;
    logic                 dneg7_reg;
    logic                 sing7_reg;

    logic signed [NW-1:0] ser_num_reg [NODES][AXES];
    logic [DW-1:0]        ser_dabs_reg;
    logic [DETW-1:0]      ser_detq_reg;
    logic                 ser_dneg_reg;
    logic                 ser_sing_reg;
    logic                 ser_valid_reg;
    logic                 ser_valid_next;
    logic [1:0]           ser_cnt_reg;
    logic [1:0]           ser_cnt_next;

    tsg_div_t             dv_in;
    tsg_div_t             dv_reg [DIV_STEPS+1];
    logic [DIV_STEPS:0]   dvv_reg;

    tsg_out_t             out_reg;
    tsg_out_t             out_next;
    logic                 out_valid_reg;

    logic signed [DQW-1:0] det_hi;
    logic signed [NW-1:0]  nsel;
    logic [NW-1:0]         nabs;

    assign adv        = !out_valid_reg || result_ready;
    assign front_adv  = adv && (!ser_valid_reg || ser_cnt_reg == LAST_NODE);
    assign item_ready = front_adv;

    assign fv_next = {fv_reg[FRONT_STAGES-1:1], item_valid};

    always_comb
    begin
        crd[0][0] = item.node0_x; crd[0][1] = item.node0_y; crd[0][2] = item.node0_z;
        crd[1][0] = item.node1_x; crd[1][1] = item.node1_y; crd[1][2] = item.node1_z;
        crd[2][0] = item.node2_x; crd[2][1] = item.node2_y; crd[2][2] = item.node2_z;
        crd[3][0] = item.node3_x; crd[3][1] = item.node3_y; crd[3][2] = item.node3_z;
    end

    // Front: Jacobian, cofactor products, adjugate, determinant, node numerators.
    always_ff @(posedge clk)
    begin
        if (front_adv)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                j1_reg[i][0] <= JW'(crd[0][i]) - JW'(crd[2][i]);
                j1_reg[i][1] <= JW'(crd[1][i]) - JW'(crd[2][i]);
                j1_reg[i][2] <= JW'(crd[3][i]) - JW'(crd[2][i]);
            end
            for (int k = 0; k < AXES; k++)
            begin
                j0_2_reg[k] <= j1_reg[0][k];
                j0_3_reg[k] <= j0_2_reg[k];
                for (int i = 0; i < AXES; i++)
                begin
                    pa_reg[k][i] <= j1_reg[(i+1)%3][(k+1)%3] * j1_reg[(i+2)%3][(k+2)%3];
                    pb_reg[k][i] <= j1_reg[(i+1)%3][(k+2)%3] * j1_reg[(i+2)%3][(k+1)%3];
                    adj3_reg[k][i] <= AW'(pa_reg[k][i]) - AW'(pb_reg[k][i]);
                    adj4_reg[k][i] <= adj3_reg[k][i];
                end
                plo_reg[k] <= j0_3_reg[k] * $signed({1'b0, adj3_reg[k][0][LOW_W-1:0]});
                phi_reg[k] <= j0_3_reg[k] * $signed(adj3_reg[k][0][AW-1:LOW_W]);
                term_reg[k] <= (DW'(phi_reg[k]) <<< LOW_W) + DW'(plo_reg[k]);
            end
            for (int i = 0; i < AXES; i++)
            begin
                num5_reg[0][i] <= NW'(adj4_reg[0][i]);
                num5_reg[1][i] <= NW'(adj4_reg[1][i]);
                num5_reg[2][i] <= -(NW'(adj4_reg[0][i]) + NW'(adj4_reg[1][i])
                                    + NW'(adj4_reg[2][i]));
                num5_reg[3][i] <= NW'(adj4_reg[2][i]);
            end
            det_reg  <= term_reg[0] + term_reg[1] + term_reg[2];
            num6_reg <= num5_reg;
            num7_reg <= num6_reg;
            dneg7_reg <= det_reg[DW-1];
            sing7_reg <= (det_reg == '0);
            dabs7_reg <= det_reg[DW-1] ? DW'(-det_reg) : DW'(det_reg);
            if (det_hi[DQW-1:DETW-1] == '0 || det_hi[DQW-1:DETW-1] == '1)
                detq7_reg <= det_hi[DETW-1:0];
            else
                detq7_reg <= det_hi[DQW-1] ? {1'b1, {(DETW-1){1'b0}}}
                                           : {1'b0, {(DETW-1){1'b1}}};
        end
    end

    assign det_hi = det_reg[DW-1:32];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fv_reg <= '0;
        else if (front_adv)
            fv_reg <= fv_next;
    end

    // Serializer: hold one element, release one node per advance.
    always_comb
    begin
        ser_valid_next = ser_valid_reg;
        ser_cnt_next   = ser_cnt_reg;
        if (adv && ser_valid_reg)
            ser_cnt_next = ser_cnt_reg + 2'd1;
        if (front_adv)
            ser_valid_next = fv_reg[FRONT_STAGES];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ser_valid_reg <= 1'b0;
            ser_cnt_reg   <= '0;
        end
        else
        begin
            ser_valid_reg <= ser_valid_next;
            ser_cnt_reg   <= ser_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (front_adv)
        begin
            ser_num_reg  <= num7_reg;
            ser_dabs_reg <= dabs7_reg;
            ser_detq_reg <= detq7_reg;
            ser_dneg_reg <= dneg7_reg;
            ser_sing_reg <= sing7_reg;
        end
    end

    always_comb
    begin
        dv_in      = '0;
        dv_in.dabs = ser_dabs_reg;
        dv_in.detq = ser_detq_reg;
        dv_in.sing = ser_sing_reg;
        dv_in.idx  = ser_cnt_reg;
        nsel = '0;
        nabs = '0;
        for (int l = 0; l < AXES; l++)
        begin
            nsel = ser_num_reg[ser_cnt_reg][l];
            nabs = nsel[NW-1] ? NW'(-nsel) : NW'(nsel);
            dv_in.neg[l] = nsel[NW-1] ^ ser_dneg_reg;
            dv_in.big[l] = (DW'(nabs) >= ser_dabs_reg);
            dv_in.rem[l] = DW'(nabs);
        end
    end

    // Divider: one quotient bit per stage on each lane.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_reg[0] <= dv_in;
            for (int s = 0; s < DIV_STEPS; s++)
                dv_reg[s+1] <= div_step(dv_reg[s]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dvv_reg <= '0;
        else if (adv)
            dvv_reg <= {dvv_reg[DIV_STEPS-1:0], ser_valid_reg};
    end

    always_comb
    begin
        out_next            = '0;
        out_next.node_index = dv_reg[DIV_STEPS].idx;
        out_next.dn_dx = finish_quo(dv_reg[DIV_STEPS].sing, dv_reg[DIV_STEPS].big[0],
                                    dv_reg[DIV_STEPS].neg[0], dv_reg[DIV_STEPS].quo[0]);
        out_next.dn_dy = finish_quo(dv_reg[DIV_STEPS].sing, dv_reg[DIV_STEPS].big[1],
                                    dv_reg[DIV_STEPS].neg[1], dv_reg[DIV_STEPS].quo[1]);
        out_next.dn_dz = finish_quo(dv_reg[DIV_STEPS].sing, dv_reg[DIV_STEPS].big[2],
                                    dv_reg[DIV_STEPS].neg[2], dv_reg[DIV_STEPS].quo[2]);
        out_next.det_j      = dv_reg[DIV_STEPS].detq;
        out_next.ip_weight  = WEIGHT_SIXTH;
        out_next.singular   = dv_reg[DIV_STEPS].sing;
        out_next.last       = (dv_reg[DIV_STEPS].idx == LAST_NODE);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= dvv_reg[DIV_STEPS];
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

[rtl/tsg_checker.sv]
// ----------------------------------------------------------------------------
// tsg_checker
// Port-level checks on the shape-gradient element and result channels.
// ----------------------------------------------------------------------------
module tsg_checker
    import tsg_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     item_valid,
    input logic     item_ready,
    input tsg_in_t  item,
    input logic     result_valid,
    input logic     result_ready,
    input tsg_out_t result
);

    // hold an offered element beat
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_ready |=> item_valid && $stable(item))
        else $error("element beat changed while stalled");

    // hold a stalled beat
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result beat changed while stalled");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.last == (result.node_index == LAST_NODE)))
        else $error("last flag disagrees with node index");

    a_sing: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.singular |->
            result.dn_dx == '0 && result.dn_dy == '0 && result.dn_dz == '0
            && result.det_j == '0)
        else $error("singular beat carries nonzero values");

    a_next: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && !result.last ##1 result_valid |->
            result.node_index == $past(result.node_index) + 2'd1)
        else $error("node order broken");

endmodule

bind tet4_shape_gradient tsg_checker u_tsg_checker (.*);

[bench/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: tet4_shape_gradient regression
// Sends tetrahedron elements and checks that each one gives four node
// gradient beats. The expected beats come from a predictor in exact
// wide-integer arithmetic. The run covers directed extremes, singular and
// near-singular shapes, random elements under three idling mixes and a long
// stall on the result side.
// ----------------------------------------------------------------------------
module tb;
    import tsg_pkg::*;

    typedef logic signed [159:0] wide_t;

    localparam wide_t MAX32 = 160'sd2147483647;
    localparam wide_t MIN32 = -160'sd2147483648;
    localparam wide_t MAX64 = 160'sd9223372036854775807;
    localparam wide_t MIN64 = -160'sd9223372036854775808;
    localparam logic signed [31:0] ONE = 32'sd65536;

    logic     clk;
    logic     rst_n;
    logic     item_valid;
    logic     item_ready;
    tsg_in_t  item;
    logic     result_valid;
    logic     result_ready;
    tsg_out_t result;

    tsg_out_t gradient_q[$];
    int       errors;
    int       snd_idle_pct;
    int       rcv_idle_pct;
    int       hold_cycles;

    tet4_shape_gradient dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic wide_t sat_to(input wide_t v, input wide_t lo, input wide_t hi);
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    task automatic predict_gradients(input tsg_in_t e);
        wide_t    p[4][3];
        wide_t    jm[3][3];
        wide_t    adj[3][3];
        wide_t    det;
        wide_t    num;
        wide_t    q;
        tsg_out_t o;
        logic     sing;
        int       i1, i2, k1, k2;
        p[0][0] = e.node0_x; p[0][1] = e.node0_y; p[0][2] = e.node0_z;
        p[1][0] = e.node1_x; p[1][1] = e.node1_y; p[1][2] = e.node1_z;
        p[2][0] = e.node2_x; p[2][1] = e.node2_y; p[2][2] = e.node2_z;
        p[3][0] = e.node3_x; p[3][1] = e.node3_y; p[3][2] = e.node3_z;
        for (int i = 0; i < 3; i++)
        begin
            jm[i][0] = p[0][i] - p[2][i];
            jm[i][1] = p[1][i] - p[2][i];
            jm[i][2] = p[3][i] - p[2][i];
        end
        for (int k = 0; k < 3; k++)
            for (int i = 0; i < 3; i++)
            begin
                i1 = (i + 1) % 3; i2 = (i + 2) % 3;
                k1 = (k + 1) % 3; k2 = (k + 2) % 3;
                adj[k][i] = jm[i1][k1] * jm[i2][k2] - jm[i1][k2] * jm[i2][k1];
            end
        det = 0;
        for (int k = 0; k < 3; k++)
            det = det + jm[0][k] * adj[k][0];
        sing = (det == 0);
        for (int n = 0; n < 4; n++)
        begin
            o = '0;
            o.node_index = 2'(n);
            for (int i = 0; i < 3; i++)
            begin
                if (n == 2)
                    num = -(adj[0][i] + adj[1][i] + adj[2][i]);
                else
                    num = adj[(n == 3) ? 2 : n][i];
                q = sing ? wide_t'(0) : sat_to((num <<< 32) / det, MIN32, MAX32);
                if (i == 0)
                    o.dn_dx = q[31:0];
                else if (i == 1)
                    o.dn_dy = q[31:0];
                else
                    o.dn_dz = q[31:0];
            end
            q = sat_to(det >>> 32, MIN64, MAX64);
            o.det_j     = q[63:0];
            o.ip_weight = WEIGHT_SIXTH;
            o.singular  = sing;
            o.last      = (n == 3);
            gradient_q.push_back(o);
        end
    endtask

    task automatic send_element(input tsg_in_t e);
        @(negedge clk);
        while ($urandom_range(99) < snd_idle_pct)
        begin
            item_valid = 1'b0;
            @(negedge clk);
        end
        item_valid = 1'b1;
        item       = e;
        forever
        begin
            @(posedge clk);
            if (item_ready)
                break;
        end
        predict_gradients(e);
    endtask

    task automatic drop_valid();
        @(negedge clk);
        item_valid = 1'b0;
    endtask

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                result_ready = 1'b0;
                hold_cycles  = hold_cycles - 1;
            end
            else
                result_ready = ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    initial
    begin
        tsg_out_t x;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && result_ready)
            begin
                if (gradient_q.size() == 0)
                begin
                    $error("unexpected result beat node_index=%0d", result.node_index);
                    errors++;
                end
                else
                begin
                    x = gradient_q.pop_front();
                    if (result.node_index !== x.node_index)
                    begin
                        $error("node_index exp %0d got %0d", x.node_index, result.node_index);
                        errors++;
                    end
                    if (result.dn_dx !== x.dn_dx)
                    begin
                        $error("dn_dx exp %0d got %0d", x.dn_dx, result.dn_dx);
                        errors++;
                    end
                    if (result.dn_dy !== x.dn_dy)
                    begin
                        $error("dn_dy exp %0d got %0d", x.dn_dy, result.dn_dy);
                        errors++;
                    end
                    if (result.dn_dz !== x.dn_dz)
                    begin
                        $error("dn_dz exp %0d got %0d", x.dn_dz, result.dn_dz);
                        errors++;
                    end
                    if (result.det_j !== x.det_j)
                    begin
                        $error("det_j exp %0d got %0d", x.det_j, result.det_j);
                        errors++;
                    end
                    if (result.ip_weight !== x.ip_weight)
                    begin
                        $error("ip_weight exp %0d got %0d", x.ip_weight, result.ip_weight);
                        errors++;
                    end
                    if (result.singular !== x.singular)
                    begin
                        $error("singular exp %0d got %0d", x.singular, result.singular);
                        errors++;
                    end
                    if (result.last !== x.last)
                    begin
                        $error("last exp %0d got %0d", x.last, result.last);
                        errors++;
                    end
                end
            end
        end
    end

    function automatic logic signed [31:0] rand_coord(input int mode);
        case (mode)
            0: return 32'($signed($urandom_range(0, 2 * 1048576)) - 1048576);
            1: return $signed($urandom());
            2: return 32'($signed($urandom_range(0, 16)) - 8);
            default: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
        endcase
    endfunction

    function automatic tsg_in_t rand_element();
        tsg_in_t e;
        int      pick;
        int      mode;
        pick = $urandom_range(99);
        mode = (pick < 60) ? 0 : (pick < 80) ? 1 : (pick < 90) ? 2 : 3;
        e = {rand_coord(mode), rand_coord(mode), rand_coord(mode),
             rand_coord(mode), rand_coord(mode), rand_coord(mode),
             rand_coord(mode), rand_coord(mode), rand_coord(mode),
             rand_coord(mode), rand_coord(mode), rand_coord(mode)};
        pick = $urandom_range(99);
        if (pick < 8)
        begin
            e.node3_x = e.node0_x;
            e.node3_y = e.node0_y;
            e.node3_z = e.node0_z;
        end
        else if (pick < 14)
        begin
            e.node0_z = e.node2_z;
            e.node1_z = e.node2_z;
            e.node3_z = e.node2_z;
        end
        return e;
    endfunction

    function automatic tsg_in_t unit_tet(input logic signed [31:0] s);
        tsg_in_t e;
        e = '0;
        e.node0_x = s;
        e.node1_y = s;
        e.node3_z = s;
        return e;
    endfunction

    task automatic test_directed();
        tsg_in_t e;
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        send_element(unit_tet(ONE));
        send_element(unit_tet(-ONE));
        send_element(unit_tet(32'sd1));
        send_element(unit_tet(32'sh7fffffff));
        send_element(unit_tet(32'sh80000000));
        send_element('0);
        send_element('1);
        send_element({12{32'sh7fffffff}});
        send_element({12{32'sh80000000}});
        e = unit_tet(32'sh7fffffff);
        e.node2_x = 32'sh80000000;
        e.node2_y = 32'sh80000000;
        e.node2_z = 32'sh80000000;
        send_element(e);
        e = unit_tet(ONE);
        e.node1_x = e.node0_x;
        e.node1_y = e.node0_y;
        e.node1_z = e.node0_z;
        send_element(e);
        e = unit_tet(ONE);
        e.node2_x = 32'sh7fffffff;
        e.node2_y = 32'sh12345678;
        e.node2_z = 32'sh80000000;
        send_element(e);
        e = unit_tet(32'sd3);
        e.node1_x = 32'sd1;
        send_element(e);
        e = {32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
             32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
             32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7fffffff};
        send_element(e);
        e = {32'haaaaaaaa, 32'h55555555, 32'h0f0f0f0f, 32'hf0f0f0f0,
             32'h33333333, 32'hcccccccc, 32'h00000000, 32'hffffffff,
             32'h01234567, 32'h89abcdef, 32'hfedcba98, 32'h76543210};
        send_element(e);
        drop_valid();
    endtask

    task automatic test_random(input int count, input int s_pct, input int r_pct);
        snd_idle_pct = s_pct;
        rcv_idle_pct = r_pct;
        for (int n = 0; n < count; n++)
            send_element(rand_element());
        drop_valid();
    endtask

    task automatic test_stall();
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        @(negedge clk);
        hold_cycles = 400;
        for (int n = 0; n < 40; n++)
            send_element(rand_element());
        drop_valid();
    endtask

    initial
    begin
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        result_ready = 1'b0;
        errors       = 0;
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        hold_cycles  = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random(130, 30, 67);
        test_random(130, 67, 30);
        test_stall();
        test_random(130, 0, 0);
        wait (gradient_q.size() == 0);
        repeat (100) @(posedge clk);
        if (errors == 0 && gradient_q.size() == 0)
            $display("tet4_shape_gradient regression: pass");
        else
            $display("tet4_shape_gradient regression: fail");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("tet4_shape_gradient regression: fail");
        $finish;
    end

endmodule

[files.f]
rtl/tsg_pkg.sv
rtl/tet4_shape_gradient.sv
rtl/tsg_checker.sv
bench/tb.sv
